/* hdl/dcc_pkg.sv */
// ----------------------------------------------------------------------------
// dcc_pkg: shared definitions of the distinct color counter
// Table size, action and status codes, stage kinds and the structs that pass
// between the lookup array, the count memory and the top level.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned ALPHA_LSB   = 24;

  // Action codes carried in the input tuser.
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Status codes carried in the output tuser.
  localparam logic [1:0] ST_COUNTED = 2'd0;
  localparam logic [1:0] ST_SKIPPED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  // What the count stage does with the entry it has fetched.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_HIT    = 2'd1;
  localparam logic [1:0] KIND_INSERT = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic               en;
    idx_t               idx;
    logic [COLOR_W-1:0] key;
  } cam_wr_t;

  typedef struct packed {
    logic hit;
    idx_t idx;
  } cam_res_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } ram_wr_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
  endfunction

endpackage

/* hdl/dcc_cam.sv */
// ----------------------------------------------------------------------------
// dcc_cam: content-addressed color lookup
// Holds one key register per table entry and compares the lookup color
// against every valid entry in parallel; returns the matching entry index.
// ----------------------------------------------------------------------------
module dcc_cam (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dcc_pkg::cnt_t               fill_i,
  input  logic [dcc_pkg::COLOR_W-1:0] key_i,
  input  dcc_pkg::cam_wr_t            wr_i,
  output dcc_pkg::cam_res_t           res_o
);

  logic [dcc_pkg::COLOR_W-1:0] keys_q [dcc_pkg::TABLE_DEPTH];
  logic [dcc_pkg::TABLE_DEPTH-1:0] lane_hit;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      keys_q[wr_i.idx] <= wr_i.key;
    end
  end

  // Entries below the fill level are the only valid ones.
  always_comb begin
    for (int i = 0; i < int'(dcc_pkg::TABLE_DEPTH); i++) begin
      lane_hit[i] = (dcc_pkg::CNT_W'(i) < fill_i) && (keys_q[i] == key_i);
    end
  end

  // Keys are unique, so an OR of the hit indices encodes the single match.
  always_comb begin
    res_o.hit = |lane_hit;
    res_o.idx = '0;
    for (int i = 0; i < int'(dcc_pkg::TABLE_DEPTH); i++) begin
      if (lane_hit[i]) begin
        res_o.idx = res_o.idx | dcc_pkg::IDX_W'(i);
      end
    end
  end

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(lane_hit))
    else $error("more than one table entry matches the lookup color");

endmodule

/* hdl/dcc_count_ram.sv */
// ----------------------------------------------------------------------------
// dcc_count_ram: entry color and count memory
// One write port and one registered read port; a read of the address written
// in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module dcc_count_ram (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  dcc_pkg::idx_t     rd_addr_i,
  output dcc_pkg::entry_t   rdata_o,
  input  dcc_pkg::ram_wr_t  wr_i
);

  dcc_pkg::entry_t mem [dcc_pkg::TABLE_DEPTH];
  dcc_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
        rdata_q <= wr_i.data;
      end else begin
        rdata_q <= mem[rd_addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/distinct_color_counter.sv */
// ----------------------------------------------------------------------------
// distinct_color_counter: histogram of distinct voxel colors
//
//   Channel  Dir  tdata (low bit up)                          tuser
//   s_axis   in   rgba[31:0], entry_index[39:32]              action[1:0]
//   m_axis   out  unique_count[8:0], voxel_count[40:9],       status[1:0]
//                 entry_color[72:41], entry_count[104:73],
//                 entry_valid[105], zero[111:106]
//
// One request is accepted per cycle unless backpressure on m_axis stalls; its result
// reaches m_axis through the input stage, the count stage and the output register.
// The rate is set by the parallel key compare in the input stage and the
// read-modify-write of the count memory, which forwards same-cycle writes.
// After reset the table is empty; no clearing pass is needed.
// Backpressure on m_axis holds only the stages that are occupied, so empty
// stages still take new requests while a result waits.
// ----------------------------------------------------------------------------
module distinct_color_counter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [39:0]   s_axis_tdata,   // rgba[31:0], entry_index[39:32]
  input  logic [1:0]    s_axis_tuser,   // action[1:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // unique_count[8:0], voxel_count[40:9],
                                        // entry_color[72:41], entry_count[104:73],
                                        // entry_valid[105], zero[111:106]
  output logic [1:0]    m_axis_tuser    // status[1:0]
);

  // Input stage.
  logic        a_valid_q;
  logic [1:0]  a_action_q;
  logic [31:0] a_rgba_q;
  logic [7:0]  a_index_q;

  // Table state.
  dcc_pkg::cnt_t distinct_q, distinct_d;
  logic [31:0]   voxel_q, voxel_d;

  // Count stage.
  logic          b_valid_q;
  logic [1:0]    b_kind_q, b_kind_d;
  dcc_pkg::idx_t b_addr_q, b_addr_d;
  logic [31:0]   b_color_q, b_color_d;
  logic [1:0]    b_status_q, b_status_d;
  logic [8:0]    b_unique_q, b_unique_d;
  logic [31:0]   b_voxel_q;
  logic          b_evalid_q, b_evalid_d;

  // Output register.
  logic        c_valid_q;
  logic [8:0]  c_unique_q;
  logic [31:0] c_voxel_q;
  logic [31:0] c_color_q;
  logic [31:0] c_count_q;
  logic        c_evalid_q;
  logic [1:0]  c_status_q;

  logic c_free, b_free, a_free, a_commit;

  dcc_pkg::cam_wr_t  cam_wr;
  dcc_pkg::cam_res_t cam_res;
  dcc_pkg::ram_wr_t  ram_wr;
  dcc_pkg::entry_t   ram_rdata;
  dcc_pkg::idx_t     rd_addr;

  logic [dcc_pkg::IDX_W+7:0] index_ext;
  logic [dcc_pkg::CNT_W+7:0] index_cmp;
  logic [dcc_pkg::CNT_W+7:0] fill_cmp;
  logic [dcc_pkg::CNT_W+8:0] unique_ext;
  logic                      read_ok;

  logic [31:0] b_count;
  logic [31:0] b_entry_color;

  assign c_free   = !c_valid_q || m_axis_tready;
  assign b_free   = !b_valid_q || c_free;
  assign a_free   = !a_valid_q || b_free;
  assign a_commit = a_valid_q && b_free;

  assign s_axis_tready = a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_free) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && s_axis_tvalid) begin
      a_action_q <= s_axis_tuser;
      a_rgba_q   <= s_axis_tdata[31:0];
      a_index_q  <= s_axis_tdata[39:32];
    end
  end

  dcc_cam u_cam (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fill_i (distinct_q),
    .key_i  (a_rgba_q),
    .wr_i   (cam_wr),
    .res_o  (cam_res)
  );

  assign index_ext  = {{dcc_pkg::IDX_W{1'b0}}, a_index_q};
  assign index_cmp  = {{dcc_pkg::CNT_W{1'b0}}, a_index_q};
  assign fill_cmp   = {8'd0, distinct_q};
  assign read_ok    = index_cmp < fill_cmp;
  assign unique_ext = {9'd0, distinct_d};

  // Decision of the input stage; state changes only when the request moves on.
  always_comb begin
    distinct_d = distinct_q;
    voxel_d    = voxel_q;
    b_kind_d   = dcc_pkg::KIND_NONE;
    b_addr_d   = cam_res.idx;
    b_color_d  = '0;
    b_status_d = dcc_pkg::ST_DONE;
    b_evalid_d = 1'b0;
    cam_wr.en  = 1'b0;
    cam_wr.idx = distinct_q[dcc_pkg::IDX_W-1:0];
    cam_wr.key = a_rgba_q;
    rd_addr    = cam_res.idx;
    case (a_action_q)
      dcc_pkg::ACT_ADD: begin
        if (a_rgba_q[31:dcc_pkg::ALPHA_LSB] == 8'd0) begin
          b_status_d = dcc_pkg::ST_SKIPPED;
        end else begin
          voxel_d = dcc_pkg::sat_inc(voxel_q);
          if (cam_res.hit) begin
            b_kind_d   = dcc_pkg::KIND_HIT;
            b_color_d  = a_rgba_q;
            b_status_d = dcc_pkg::ST_COUNTED;
            b_evalid_d = 1'b1;
          end else if (distinct_q < dcc_pkg::CNT_W'(dcc_pkg::TABLE_DEPTH)) begin
            b_kind_d   = dcc_pkg::KIND_INSERT;
            b_addr_d   = distinct_q[dcc_pkg::IDX_W-1:0];
            rd_addr    = distinct_q[dcc_pkg::IDX_W-1:0];
            b_color_d  = a_rgba_q;
            b_status_d = dcc_pkg::ST_COUNTED;
            b_evalid_d = 1'b1;
            cam_wr.en  = a_commit;
            distinct_d = distinct_q + dcc_pkg::CNT_W'(1);
          end else begin
            b_status_d = dcc_pkg::ST_FULL;
          end
        end
      end
      dcc_pkg::ACT_READ: begin
        rd_addr  = index_ext[dcc_pkg::IDX_W-1:0];
        b_addr_d = index_ext[dcc_pkg::IDX_W-1:0];
        if (read_ok) begin
          b_kind_d   = dcc_pkg::KIND_READ;
          b_evalid_d = 1'b1;
        end
      end
      dcc_pkg::ACT_CLEAR: begin
        distinct_d = '0;
        voxel_d    = '0;
      end
      default: begin
      end
    endcase
  end

  assign b_unique_d = unique_ext[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      distinct_q <= '0;
      voxel_q    <= '0;
    end else if (a_commit) begin
      distinct_q <= distinct_d;
      voxel_q    <= voxel_d;
    end
  end

  dcc_count_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (b_free),
    .rd_addr_i (rd_addr),
    .rdata_o   (ram_rdata),
    .wr_i      (ram_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_kind_q  <= dcc_pkg::KIND_NONE;
    end else if (b_free) begin
      b_valid_q <= a_valid_q;
      b_kind_q  <= b_kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_free) begin
      b_addr_q   <= b_addr_d;
      b_color_q  <= b_color_d;
      b_status_q <= b_status_d;
      b_unique_q <= b_unique_d;
      b_voxel_q  <= voxel_d;
      b_evalid_q <= b_evalid_d;
    end
  end

  // Count stage: finish the entry and write it back as it leaves.
  always_comb begin
    b_count       = '0;
    b_entry_color = b_color_q;
    case (b_kind_q)
      dcc_pkg::KIND_HIT:    b_count = dcc_pkg::sat_inc(ram_rdata.count);
      dcc_pkg::KIND_INSERT: b_count = 32'd1;
      dcc_pkg::KIND_READ: begin
        b_count       = ram_rdata.count;
        b_entry_color = ram_rdata.color;
      end
      default:              b_count = '0;
    endcase
  end

  assign ram_wr.en         = b_valid_q && c_free &&
                             ((b_kind_q == dcc_pkg::KIND_HIT) ||
                              (b_kind_q == dcc_pkg::KIND_INSERT));
  assign ram_wr.addr       = b_addr_q;
  assign ram_wr.data.color = b_color_q;
  assign ram_wr.data.count = b_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_free) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_free) begin
      c_unique_q <= b_unique_q;
      c_voxel_q  <= b_voxel_q;
      c_color_q  <= b_entry_color;
      c_count_q  <= b_count;
      c_evalid_q <= b_evalid_q;
      c_status_q <= b_status_q;
    end
  end

  assign m_axis_tvalid = c_valid_q;
  assign m_axis_tdata  = {6'd0, c_evalid_q, c_count_q, c_color_q, c_voxel_q, c_unique_q};
  assign m_axis_tuser  = c_status_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    distinct_q <= dcc_pkg::CNT_W'(dcc_pkg::TABLE_DEPTH))
    else $error("table fill level exceeds the table depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (distinct_q != $past(distinct_q)) |->
      ((distinct_q == $past(distinct_q) + dcc_pkg::CNT_W'(1)) || (distinct_q == '0)))
    else $error("table fill level moved by more than one entry");

  a_counted_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == dcc_pkg::ST_COUNTED)) |->
      (c_evalid_q && (c_count_q != '0) && (c_voxel_q != '0)))
    else $error("counted voxel without a valid, nonzero entry");

  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && c_evalid_q) |->
      ((m_axis_tuser == dcc_pkg::ST_COUNTED) || (m_axis_tuser == dcc_pkg::ST_DONE)))
    else $error("valid entry reported with a skip or full status");

endmodule
